@@ rtl/core/button_click_gesture_classifier_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Button click gesture classifier - assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_GESTURE_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_GESTURE_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication
`define BCGC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcgc assertion failed");

// next-cycle implication
`define BCGC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcgc assertion failed");

`endif

@@ rtl/core/bcgc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcgc_pkg
// Widths, register map and reset values of the button click classifier.
// ----------------------------------------------------------------------------
package bcgc_pkg;

   localparam int MASK_W = 32;
   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   typedef enum logic [0:0] {
      REG_DOUBLE_CLICK = 1'b0,
      REG_LONG_PRESS   = 1'b1
   } reg_index_type;

   localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd500;

endpackage

@@ rtl/core/button_click_gesture_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// button_click_gesture_classifier_unit
// Per-button press, double click, short click and long click detector.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one poll per transaction (button levels, millisecond tick).
//   rsp channel: one result transaction per poll (down, pressed, double,
//   short and long masks), in poll order.
//   A transaction moves when valid is high and stall is low.
//   Pipeline: a poll accepted into the input register moves to the result
//   register when that is empty or being drained, and is then on rsp.
//   Throughput: one poll per cycle while req_stall is low; each button
//   lane does two 32-bit subtracts and three compares per poll between the
//   input and result registers. A new poll is taken while a result waits,
//   as long as the input register can move on; req_stall rises only when
//   both registers are full and rsp_stall is high.
//   Reset (synchronous): buttons all up, tick history zero, double click
//   time 300 ms, long press time 500 ms, both pipeline registers empty.
//   Configuration: APB registers at 0x0 (double_click_ms) and 0x4
//   (long_press_ms), low 16 bits kept; write only while idle.
// ----------------------------------------------------------------------------
`include "button_click_gesture_classifier_unit_macros.svh"

module button_click_gesture_classifier_unit
   import bcgc_pkg::*;
#(
   parameter int NUM_BUTTONS = 32
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MASK_W-1:0] req_button_levels,
   input  logic [TIME_W-1:0] req_time_ms,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [MASK_W-1:0] rsp_down_mask,
   output logic [MASK_W-1:0] rsp_pressed_mask,
   output logic [MASK_W-1:0] rsp_double_mask,
   output logic [MASK_W-1:0] rsp_short_mask,
   output logic [MASK_W-1:0] rsp_long_mask,

   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int NB = NUM_BUTTONS;

   // configuration
   logic [CFG_W-1:0] double_click_ms_ff, double_click_ms_in;
   logic [CFG_W-1:0] long_press_ms_ff, long_press_ms_in;
   logic             csr_write;
   reg_index_type    csr_index;

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic req_accept;
   logic advance;

   // input register
   logic [NB-1:0]     s1_levels_ff, s1_levels_in;
   logic [TIME_W-1:0] s1_time_ff, s1_time_in;

   // button history
   logic [NB-1:0]     prev_levels_ff;
   logic [TIME_W-1:0] down_time_ff [NB];
   logic [TIME_W-1:0] up_time_ff [NB];

   // lane results and result register
   logic [NB-1:0] pressed_in, double_in, short_in, long_in;
   logic [NB-1:0] down_ff, pressed_ff, double_ff, short_ff, long_ff;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      double_click_ms_in = double_click_ms_ff;
      long_press_ms_in   = long_press_ms_ff;
      prdata             = '0;
      unique case (csr_index)
         REG_DOUBLE_CLICK: begin
            prdata = DATA_W'(double_click_ms_ff);
            if (csr_write) double_click_ms_in = pwdata[CFG_W-1:0];
         end
         REG_LONG_PRESS: begin
            prdata = DATA_W'(long_press_ms_ff);
            if (csr_write) long_press_ms_in = pwdata[CFG_W-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         double_click_ms_ff <= DOUBLE_CLICK_RESET;
         long_press_ms_ff   <= LONG_PRESS_RESET;
      end else begin
         double_click_ms_ff <= double_click_ms_in;
         long_press_ms_ff   <= long_press_ms_in;
      end
   end

   // ---------------- handshake ----------------
   assign advance    = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & out_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff & ~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------- input register ----------------
   assign s1_levels_in = req_accept ? req_button_levels[NB-1:0] : s1_levels_ff;
   assign s1_time_in   = req_accept ? req_time_ms : s1_time_ff;

   always_ff @(posedge clock) begin
      s1_levels_ff <= s1_levels_in;
      s1_time_ff   <= s1_time_in;
   end

   // ---------------- button lanes ----------------
   for (genvar i = 0; i < NB; i++) begin : g_lane
      logic [TIME_W-1:0] down_delta;
      logic [TIME_W-1:0] up_delta;
      logic              level;
      logic              was;

      assign level      = s1_levels_ff[i];
      assign was        = prev_levels_ff[i];
      assign down_delta = s1_time_ff - down_time_ff[i];
      assign up_delta   = s1_time_ff - up_time_ff[i];

      assign pressed_in[i] = level & ~was;
      assign double_in[i]  = level & ~was & (down_delta < TIME_W'(double_click_ms_ff));
      assign short_in[i]   = ~level & was & (up_delta < TIME_W'(long_press_ms_ff));
      assign long_in[i]    = ~level & was & (up_delta > TIME_W'(long_press_ms_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
         for (int i = 0; i < NB; i++) begin
            down_time_ff[i] <= '0;
            up_time_ff[i]   <= '0;
         end
      end else if (advance) begin
         prev_levels_ff <= s1_levels_ff;
         for (int i = 0; i < NB; i++) begin
            if (s1_levels_ff[i]) begin
               down_time_ff[i] <= s1_time_ff;
            end else begin
               up_time_ff[i] <= s1_time_ff;
            end
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         down_ff    <= s1_levels_ff;
         pressed_ff <= pressed_in;
         double_ff  <= double_in;
         short_ff   <= short_in;
         long_ff    <= long_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_down_mask    = MASK_W'(down_ff);
   assign rsp_pressed_mask = MASK_W'(pressed_ff);
   assign rsp_double_mask  = MASK_W'(double_ff);
   assign rsp_short_mask   = MASK_W'(short_ff);
   assign rsp_long_mask    = MASK_W'(long_ff);

   // ---------------- assertions ----------------
   `BCGC_ASSERT_SAME(a_press_subsets, clock, reset, rsp_valid, ((rsp_pressed_mask & ~rsp_down_mask) == '0) && ((rsp_double_mask & ~rsp_pressed_mask) == '0))
   `BCGC_ASSERT_SAME(a_release_disjoint, clock, reset, rsp_valid, (((rsp_short_mask | rsp_long_mask) & rsp_down_mask) == '0) && ((rsp_short_mask & rsp_long_mask) == '0))
   `BCGC_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_accept, s1_valid_ff)
   `BCGC_ASSERT_NEXT(a_drain_empties, clock, reset, rsp_valid && !rsp_stall && !s1_valid_ff, !rsp_valid)

endmodule
